// ===== hw/rtl/dssr_pkg.sv =====
`default_nettype none

package dssr_pkg;

  // Default number of words per stack
  localparam int STACK_DEPTH_DEF = 512;

  // Field widths of the beats
  localparam int WORD_W  = 32;
  localparam int REQ_W   = 4;
  localparam int STAT_W  = 2;
  localparam int COUNT_W = 10;

  // Request opcodes
  localparam logic [REQ_W-1:0] REQ_PUSH_A    = 4'd0;
  localparam logic [REQ_W-1:0] REQ_PUSH_B    = 4'd1;
  localparam logic [REQ_W-1:0] REQ_POP_A     = 4'd2;
  localparam logic [REQ_W-1:0] REQ_POP_B     = 4'd3;
  localparam logic [REQ_W-1:0] REQ_SWAP_A    = 4'd4;
  localparam logic [REQ_W-1:0] REQ_SWAP_B    = 4'd5;
  localparam logic [REQ_W-1:0] REQ_SWAP_BOTH = 4'd6;
  localparam logic [REQ_W-1:0] REQ_MOVE_AB   = 4'd7;
  localparam logic [REQ_W-1:0] REQ_MOVE_BA   = 4'd8;
  localparam logic [REQ_W-1:0] REQ_ROT_A     = 4'd9;
  localparam logic [REQ_W-1:0] REQ_ROT_B     = 4'd10;

  // Status codes
  localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
  localparam logic [STAT_W-1:0] ST_FULL  = 2'd1;
  localparam logic [STAT_W-1:0] ST_EMPTY = 2'd2;
  localparam logic [STAT_W-1:0] ST_FEW   = 2'd3;

  // Shift command applied to every cell of one chain
  typedef enum logic [2:0] {
    CH_HOLD = 3'd0,
    CH_PUSH = 3'd1,
    CH_POP  = 3'd2,
    CH_SWAP = 3'd3,
    CH_ROT  = 3'd4
  } chain_op_t;

  typedef struct packed {
    chain_op_t         op;
    logic [WORD_W-1:0] value;
  } chain_cmd_t;

  typedef struct packed {
    logic [REQ_W-1:0]         req_type;
    logic signed [WORD_W-1:0] push_value;
  } req_item_t;

  typedef struct packed {
    logic [STAT_W-1:0]        status;
    logic signed [WORD_W-1:0] popped_value;
    logic signed [WORD_W-1:0] top_of_a;
    logic signed [WORD_W-1:0] top_of_b;
    logic [COUNT_W-1:0]       count_a;
    logic [COUNT_W-1:0]       count_b;
  } rsp_item_t;

endpackage

`default_nettype wire

// ===== hw/rtl/dssr_cell.sv =====
`default_nettype none

module dssr_cell
  import dssr_pkg::*;
#(
  parameter int INDEX = 0,
  parameter int CNT_W = 10
) (
  input  wire logic              clk,
  input  wire chain_op_t         op,
  input  wire logic [WORD_W-1:0] prv_word,
  input  wire logic [WORD_W-1:0] nxt_word,
  input  wire logic [WORD_W-1:0] head_word,
  input  wire logic [CNT_W-1:0]  last_live,
  output logic      [WORD_W-1:0] word
);

  localparam logic [CNT_W-1:0] MY_POS = CNT_W'(INDEX);

  // Take a word from a neighbor, or from the head on the wrap of a rotate
  always_ff @(posedge clk) begin
    case (op)
      CH_PUSH: word <= prv_word;
      CH_POP:  word <= nxt_word;
      CH_SWAP: begin
        if (INDEX == 0) begin
          word <= nxt_word;
        end else if (INDEX == 1) begin
          word <= prv_word;
        end
      end
      CH_ROT: begin
        if (MY_POS < last_live) begin
          word <= nxt_word;
        end else if (MY_POS == last_live) begin
          word <= head_word;
        end
      end
      default: begin
      end
    endcase
  end

endmodule

`default_nettype wire

// ===== hw/rtl/dssr_chain.sv =====
`default_nettype none

module dssr_chain
  import dssr_pkg::*;
#(
  parameter int DEPTH = STACK_DEPTH_DEF,
  parameter int CNT_W = $clog2(DEPTH + 1)
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire chain_cmd_t        cmd,
  output logic      [WORD_W-1:0] head,
  output logic      [WORD_W-1:0] second,
  output logic      [CNT_W-1:0]  count
);

  logic [WORD_W-1:0] words [DEPTH];
  logic [CNT_W-1:0]  last_live;

  assign last_live = count - CNT_W'(1);
  assign head      = words[0];
  assign second    = words[1];

  // Row of cells, top of stack in cell 0
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [WORD_W-1:0] prv_word;
    logic [WORD_W-1:0] nxt_word;

    if (i == 0) begin : g_first
      assign prv_word = cmd.value;
    end else begin : g_mid_prv
      assign prv_word = words[i-1];
    end

    if (i == DEPTH - 1) begin : g_last
      assign nxt_word = words[i];
    end else begin : g_mid_nxt
      assign nxt_word = words[i+1];
    end

    dssr_cell #(
      .INDEX (i),
      .CNT_W (CNT_W)
    ) u_cell (
      .clk       (clk),
      .op        (cmd.op),
      .prv_word  (prv_word),
      .nxt_word  (nxt_word),
      .head_word (words[0]),
      .last_live (last_live),
      .word      (words[i])
    );
  end

  // Track fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else begin
      case (cmd.op)
        CH_PUSH: count <= count + CNT_W'(1);
        CH_POP:  count <= count - CNT_W'(1);
        default: begin
        end
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/dual_stack_swap_rotate_engine.sv =====
`default_nettype none

// Two bounded stacks of 32-bit words, each built as a row of STACK_DEPTH
// register cells with the top word in the first cell; push, pop and move
// shift every cell of a row at once, rotate turns the live cells and swap
// exchanges the first two. A request beat is captured into a holding
// register; once the response register is free the rows shift and the
// response register loads, and only then is a new request taken. The response
// register lets the next request in while a response still waits. Stack
// contents need no clearing; reset clears only the counts, busy and rsp_valid.
module dual_stack_swap_rotate_engine
  import dssr_pkg::*;
#(
  parameter int STACK_DEPTH = STACK_DEPTH_DEF
) (
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      req_valid,
  output logic           req_ready,
  input  wire req_item_t req,
  output logic           rsp_valid,
  input  wire logic      rsp_ready,
  output rsp_item_t      rsp
);

  localparam int CNT_W = $clog2(STACK_DEPTH + 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(STACK_DEPTH);
  localparam logic [CNT_W-1:0] ONE_CNT  = CNT_W'(1);

  logic              busy;
  req_item_t         req_hold;
  logic              exec;

  chain_cmd_t        cmd_a;
  chain_cmd_t        cmd_b;
  logic [WORD_W-1:0] head_a;
  logic [WORD_W-1:0] head_b;
  logic [WORD_W-1:0] second_a;
  logic [WORD_W-1:0] second_b;
  logic [CNT_W-1:0]  cnt_a;
  logic [CNT_W-1:0]  cnt_b;

  logic [STAT_W-1:0] status_next;
  logic [WORD_W-1:0] popped_next;
  logic [WORD_W-1:0] top_a_next;
  logic [WORD_W-1:0] top_b_next;
  logic [CNT_W-1:0]  cnt_a_next;
  logic [CNT_W-1:0]  cnt_b_next;
  rsp_item_t         rsp_next;

  logic full_a, full_b, empty_a, empty_b, few_a, few_b;

  assign req_ready = !busy;
  assign exec      = busy && (!rsp_valid || rsp_ready);

  assign full_a  = (cnt_a == FULL_CNT);
  assign full_b  = (cnt_b == FULL_CNT);
  assign empty_a = (cnt_a == '0);
  assign empty_b = (cnt_b == '0);
  assign few_a   = (cnt_a < CNT_W'(2));
  assign few_b   = (cnt_b < CNT_W'(2));

  // Decode the held request into chain commands and the response
  always_comb begin
    status_next = ST_OK;
    popped_next = '0;
    top_a_next  = head_a;
    top_b_next  = head_b;
    cnt_a_next  = cnt_a;
    cnt_b_next  = cnt_b;
    cmd_a       = '{op: CH_HOLD, value: '0};
    cmd_b       = '{op: CH_HOLD, value: '0};

    unique case (req_hold.req_type)
      REQ_PUSH_A: begin
        if (full_a) begin
          status_next = ST_FULL;
        end else begin
          cmd_a      = '{op: CH_PUSH, value: req_hold.push_value};
          top_a_next = req_hold.push_value;
          cnt_a_next = cnt_a + ONE_CNT;
        end
      end
      REQ_PUSH_B: begin
        if (full_b) begin
          status_next = ST_FULL;
        end else begin
          cmd_b      = '{op: CH_PUSH, value: req_hold.push_value};
          top_b_next = req_hold.push_value;
          cnt_b_next = cnt_b + ONE_CNT;
        end
      end
      REQ_POP_A: begin
        if (empty_a) begin
          status_next = ST_EMPTY;
        end else begin
          cmd_a.op    = CH_POP;
          popped_next = head_a;
          top_a_next  = second_a;
          cnt_a_next  = cnt_a - ONE_CNT;
        end
      end
      REQ_POP_B: begin
        if (empty_b) begin
          status_next = ST_EMPTY;
        end else begin
          cmd_b.op    = CH_POP;
          popped_next = head_b;
          top_b_next  = second_b;
          cnt_b_next  = cnt_b - ONE_CNT;
        end
      end
      REQ_SWAP_A: begin
        if (few_a) begin
          status_next = ST_FEW;
        end else begin
          cmd_a.op   = CH_SWAP;
          top_a_next = second_a;
        end
      end
      REQ_SWAP_B: begin
        if (few_b) begin
          status_next = ST_FEW;
        end else begin
          cmd_b.op   = CH_SWAP;
          top_b_next = second_b;
        end
      end
      REQ_SWAP_BOTH: begin
        if (few_a || few_b) begin
          status_next = ST_FEW;
        end else begin
          cmd_a.op   = CH_SWAP;
          cmd_b.op   = CH_SWAP;
          top_a_next = second_a;
          top_b_next = second_b;
        end
      end
      REQ_MOVE_AB: begin
        if (empty_a) begin
          status_next = ST_EMPTY;
        end else if (full_b) begin
          status_next = ST_FULL;
        end else begin
          cmd_a.op   = CH_POP;
          cmd_b      = '{op: CH_PUSH, value: head_a};
          top_a_next = second_a;
          top_b_next = head_a;
          cnt_a_next = cnt_a - ONE_CNT;
          cnt_b_next = cnt_b + ONE_CNT;
        end
      end
      REQ_MOVE_BA: begin
        if (empty_b) begin
          status_next = ST_EMPTY;
        end else if (full_a) begin
          status_next = ST_FULL;
        end else begin
          cmd_b.op   = CH_POP;
          cmd_a      = '{op: CH_PUSH, value: head_b};
          top_b_next = second_b;
          top_a_next = head_b;
          cnt_b_next = cnt_b - ONE_CNT;
          cnt_a_next = cnt_a + ONE_CNT;
        end
      end
      REQ_ROT_A: begin
        if (empty_a) begin
          status_next = ST_EMPTY;
        end else if (!few_a) begin
          cmd_a.op   = CH_ROT;
          top_a_next = second_a;
        end
      end
      REQ_ROT_B: begin
        if (empty_b) begin
          status_next = ST_EMPTY;
        end else if (!few_b) begin
          cmd_b.op   = CH_ROT;
          top_b_next = second_b;
        end
      end
      default: begin
      end
    endcase

    // Drop the commands unless this is the execute cycle
    if (!exec) begin
      cmd_a.op = CH_HOLD;
      cmd_b.op = CH_HOLD;
    end

    rsp_next.status       = status_next;
    rsp_next.popped_value = popped_next;
    rsp_next.top_of_a     = (cnt_a_next == '0) ? '0 : top_a_next;
    rsp_next.top_of_b     = (cnt_b_next == '0) ? '0 : top_b_next;
    rsp_next.count_a      = COUNT_W'(cnt_a_next);
    rsp_next.count_b      = COUNT_W'(cnt_b_next);
  end

  // Capture the request beat, then execute once the response slot is free
  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      rsp_valid <= 1'b0;
    end else begin
      if (req_valid && req_ready) begin
        busy <= 1'b1;
      end else if (exec) begin
        busy <= 1'b0;
      end

      if (exec) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  // Hold payloads
  always_ff @(posedge clk) begin
    if (req_valid && req_ready) begin
      req_hold <= req;
    end
    if (exec) begin
      rsp <= rsp_next;
    end
  end

  dssr_chain #(
    .DEPTH (STACK_DEPTH),
    .CNT_W (CNT_W)
  ) u_chain_a (
    .clk    (clk),
    .rst    (rst),
    .cmd    (cmd_a),
    .head   (head_a),
    .second (second_a),
    .count  (cnt_a)
  );

  dssr_chain #(
    .DEPTH (STACK_DEPTH),
    .CNT_W (CNT_W)
  ) u_chain_b (
    .clk    (clk),
    .rst    (rst),
    .cmd    (cmd_b),
    .head   (head_b),
    .second (second_b),
    .count  (cnt_b)
  );

endmodule

`default_nettype wire
